FILE: src/staggered_grid_transfer_stencil_defines.svh
// Assertion helpers for the transfer stencil block.
`ifndef STAGGERED_GRID_TRANSFER_STENCIL_DEFINES_SVH
`define STAGGERED_GRID_TRANSFER_STENCIL_DEFINES_SVH

`ifndef SYNTHESIS
`define SGTS_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define SGTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SGTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SGTS_ASSERT(lbl, clk, rstn, expr)
`define SGTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SGTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: src/sgts_pkg.sv
`default_nettype none
package sgts_pkg;
    localparam int GRID_W = 11;
    localparam int ROW_W = 23;
    localparam int COL_W = 21;
    localparam int WGT_W = 3;
    localparam int DIVR_W = 4;
    localparam int FUNC_W = 3;
    localparam int N_W = 12;
    localparam int PROD_W = 24;
    localparam int Q_W = 24;
    localparam int DIV_STAGES = 6;
    localparam int BITS_PER_STAGE = Q_W / DIV_STAGES;
    localparam int MAX_ENT = 6;
    localparam int CNT_W = 3;
    localparam int IDX_W = 3;
    localparam int DEF_MAX_GRID = 1024;
    localparam logic [GRID_W-1:0] GRID_RESET = 11'd16;

    localparam logic [FUNC_W-1:0] FN_RESTRICT_U = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RESTRICT_V = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RESTRICT_P = 3'd2;
    localparam logic [FUNC_W-1:0] FN_PROLONG_U = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PROLONG_V = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PROLONG_P = 3'd5;

    localparam logic [DIVR_W-1:0] DIVR_UV = 4'd8;
    localparam logic [DIVR_W-1:0] DIVR_RP = 4'd4;
    localparam logic [DIVR_W-1:0] DIVR_PP = 4'd6;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [N_W-1:0] n;
        logic inr;
    } sgts_ctx_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [WGT_W-1:0] wgt;
    } sgts_ent_t;

    typedef struct packed {
        sgts_ent_t [MAX_ENT-1:0] ent;
        logic [CNT_W-1:0] cnt;
        logic [DIVR_W-1:0] divr;
    } sgts_row_t;
endpackage
`default_nettype wire

FILE: src/staggered_grid_transfer_stencil.sv
// Output: a row's entries (one to six) are shown one at a time, each held
// until m_tready; a row with no entries never reaches the output. The
// eleven-stage pipeline (range check, six-stage radix-16 divider, stencil
// build) takes a row every cycle while the output register is idle or its
// last entry is being accepted; otherwise the whole pipeline holds.
// Reset: synchronous active-low aresetn clears valid bits and sets grid_size to 16.
`default_nettype none
`include "staggered_grid_transfer_stencil_defines.svh"
module staggered_grid_transfer_stencil #(
    parameter int MAX_GRID = sgts_pkg::DEF_MAX_GRID
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,   // grid_size
    input  wire logic s_tvalid,
    output logic s_tready,
    input  wire logic [23:0] s_tdata,       // [22:0] row_index
    input  wire logic [2:0] s_tuser,        // [2:0] func
    output logic m_tvalid,
    input  wire logic m_tready,
    output logic [31:0] m_tdata,            // [20:0] column, [23:21] weight, [27:24] divisor
    output logic m_tlast                    // last_entry
);
    logic [sgts_pkg::GRID_W-1:0] grid_reg;
    logic en;

    logic p_valid;
    sgts_pkg::sgts_ctx_t p_ctx;
    logic [sgts_pkg::ROW_W-1:0] p_row;
    logic [sgts_pkg::N_W-1:0] p_d;

    logic d_valid;
    sgts_pkg::sgts_ctx_t d_ctx;
    logic [sgts_pkg::Q_W-1:0] d_q;
    logic [sgts_pkg::N_W-1:0] d_rem;

    logic g_valid;
    sgts_pkg::sgts_row_t g_row;

    logic busy_reg;
    logic [sgts_pkg::IDX_W-1:0] idx_reg;
    sgts_pkg::sgts_row_t row_reg;
    logic last_c;
    sgts_pkg::sgts_ent_t cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg <= sgts_pkg::GRID_RESET;
        end else if (cfg_wr_en) begin
            grid_reg <= cfg_wr_data;
        end
    end

    assign last_c = (idx_reg == sgts_pkg::IDX_W'(row_reg.cnt - 1'b1));
    // whole pipeline advances when the output row is empty or finishing
    assign en = !busy_reg || (m_tready && last_c);
    assign s_tready = en;

    sgts_prep #(.MAX_GRID(MAX_GRID)) u_prep (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .func(s_tuser), .row(s_tdata[22:0]), .grid(grid_reg),
        .out_valid(p_valid), .out_ctx(p_ctx), .out_row(p_row), .out_d(p_d)
    );

    sgts_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(p_valid), .in_ctx(p_ctx), .in_row(p_row), .in_d(p_d),
        .out_valid(d_valid), .out_ctx(d_ctx), .out_q(d_q), .out_rem(d_rem)
    );

    sgts_gen u_gen (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d_valid), .in_ctx(d_ctx), .in_q(d_q), .in_rem(d_rem),
        .out_valid(g_valid), .out_row(g_row)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
        end else if (en) begin
            busy_reg <= g_valid && (g_row.cnt != '0);
            idx_reg <= '0;
        end else if (m_tready) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg <= g_row;
        end
    end

    assign cur = row_reg.ent[idx_reg];
    assign m_tvalid = busy_reg;
    assign m_tlast = last_c;
    assign m_tdata = {4'd0, row_reg.divr, cur.wgt, cur.col};

    `SGTS_ASSERT_IMPL(a_busy_cnt, aclk, aresetn, busy_reg,
        row_reg.cnt != '0 && idx_reg < row_reg.cnt)
    `SGTS_ASSERT_NEXT(a_advance, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
        m_tvalid && idx_reg == $past(idx_reg) + 1'b1)
    `SGTS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        $stable(idx_reg) && m_tvalid)
    `SGTS_ASSERT(a_no_accept_busy, aclk, aresetn,
        !(s_tready && m_tvalid && !(m_tready && m_tlast)))
endmodule
`default_nettype wire

FILE: src/sgts_prep.sv
`default_nettype none
module sgts_prep #(
    parameter int MAX_GRID = sgts_pkg::DEF_MAX_GRID
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire logic [sgts_pkg::FUNC_W-1:0] func,
    input  wire logic [sgts_pkg::ROW_W-1:0] row,
    input  wire logic [sgts_pkg::GRID_W-1:0] grid,
    output logic out_valid,
    output sgts_pkg::sgts_ctx_t out_ctx,
    output logic [sgts_pkg::ROW_W-1:0] out_row,
    output logic [sgts_pkg::N_W-1:0] out_d
);
    localparam int NW = sgts_pkg::N_W;

    logic [NW-1:0] n_c, nr_c, np_c, d_c, ma_c, mb_c;

    logic v1_reg, v2_reg, v3_reg;
    logic [sgts_pkg::FUNC_W-1:0] f1_reg, f2_reg, f3_reg;
    logic [sgts_pkg::ROW_W-1:0] r1_reg, r2_reg, r3_reg;
    logic [NW-1:0] n1_reg, n2_reg, n3_reg, d1_reg, d2_reg, d3_reg;
    logic [NW-1:0] ma1_reg, mb1_reg;
    logic [sgts_pkg::PROD_W-1:0] p2_reg;
    logic inr3_reg;

    always_comb begin
        n_c = ({21'd0, grid} > MAX_GRID) ? NW'(MAX_GRID) : NW'(grid);
        nr_c = n_c >> 1;
        np_c = {n_c[NW-2:0], 1'b0};
        case (func)
            sgts_pkg::FN_RESTRICT_U: begin
                d_c = nr_c + 1'b1; ma_c = nr_c; mb_c = nr_c + 1'b1;
            end
            sgts_pkg::FN_RESTRICT_V: begin
                d_c = nr_c; ma_c = nr_c; mb_c = nr_c + 1'b1;
            end
            sgts_pkg::FN_RESTRICT_P: begin
                d_c = nr_c; ma_c = nr_c; mb_c = nr_c;
            end
            sgts_pkg::FN_PROLONG_U: begin
                d_c = np_c + 1'b1; ma_c = np_c; mb_c = np_c + 1'b1;
            end
            sgts_pkg::FN_PROLONG_V: begin
                d_c = np_c; ma_c = np_c; mb_c = np_c + 1'b1;
            end
            sgts_pkg::FN_PROLONG_P: begin
                d_c = np_c; ma_c = np_c; mb_c = np_c;
            end
            default: begin
                // unused selector: zero row count, never in range
                d_c = NW'(1); ma_c = '0; mb_c = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= func; r1_reg <= row; n1_reg <= n_c; d1_reg <= d_c;
            ma1_reg <= ma_c; mb1_reg <= mb_c;
            f2_reg <= f1_reg; r2_reg <= r1_reg; n2_reg <= n1_reg; d2_reg <= d1_reg;
            p2_reg <= ma1_reg * mb1_reg;
            f3_reg <= f2_reg; r3_reg <= r2_reg; n3_reg <= n2_reg; d3_reg <= d2_reg;
            inr3_reg <= {1'b0, r2_reg} < p2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_ctx = '{func: f3_reg, n: n3_reg, inr: inr3_reg};
    assign out_row = r3_reg;
    assign out_d = d3_reg;
endmodule
`default_nettype wire

FILE: src/sgts_div.sv
`default_nettype none
module sgts_div (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_valid,
    input  sgts_pkg::sgts_ctx_t in_ctx,
    input  wire logic [sgts_pkg::ROW_W-1:0] in_row,
    input  wire logic [sgts_pkg::N_W-1:0] in_d,
    output logic out_valid,
    output sgts_pkg::sgts_ctx_t out_ctx,
    output logic [sgts_pkg::Q_W-1:0] out_q,
    output logic [sgts_pkg::N_W-1:0] out_rem
);
    localparam int NS = sgts_pkg::DIV_STAGES;
    localparam int BPS = sgts_pkg::BITS_PER_STAGE;
    localparam int QW = sgts_pkg::Q_W;
    localparam int NW = sgts_pkg::N_W;

    logic v_reg [NS];
    sgts_pkg::sgts_ctx_t ctx_reg [NS];
    logic [QW-1:0] dq_reg [NS];
    logic [NW-1:0] rem_reg [NS];
    logic [NW-1:0] d_reg [NS];

    // dq shifts dividend bits out at the top and quotient bits in at the bottom
    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [QW-1:0] dq_in, dq_next;
        logic [NW-1:0] rem_in, rem_next, d_in;
        logic v_in;
        sgts_pkg::sgts_ctx_t ctx_in;

        if (s == 0) begin : g_first
            assign dq_in = QW'(in_row);
            assign rem_in = '0;
            assign d_in = in_d;
            assign v_in = in_valid;
            assign ctx_in = in_ctx;
        end else begin : g_rest
            assign dq_in = dq_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign d_in = d_reg[s-1];
            assign v_in = v_reg[s-1];
            assign ctx_in = ctx_reg[s-1];
        end

        always_comb begin
            logic [NW:0] sh;
            dq_next = dq_in;
            rem_next = rem_in;
            for (int i = 0; i < BPS; i++) begin
                sh = {rem_next, dq_next[QW-1]};
                dq_next = {dq_next[QW-2:0], 1'b0};
                if (sh >= {1'b0, d_in}) begin
                    rem_next = NW'(sh - {1'b0, d_in});
                    dq_next[0] = 1'b1;
                end else begin
                    rem_next = NW'(sh);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dq_reg[s] <= dq_next;
                rem_reg[s] <= rem_next;
                d_reg[s] <= d_in;
                ctx_reg[s] <= ctx_in;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_ctx = ctx_reg[NS-1];
    assign out_q = dq_reg[NS-1];
    assign out_rem = rem_reg[NS-1];
endmodule
`default_nettype wire

FILE: src/sgts_gen.sv
`default_nettype none
module sgts_gen (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_valid,
    input  sgts_pkg::sgts_ctx_t in_ctx,
    input  wire logic [sgts_pkg::Q_W-1:0] in_q,
    input  wire logic [sgts_pkg::N_W-1:0] in_rem,
    output logic out_valid,
    output sgts_pkg::sgts_row_t out_row
);
    localparam int NW = sgts_pkg::N_W;
    localparam int CW = sgts_pkg::COL_W;
    localparam int QW = sgts_pkg::Q_W;

    typedef struct packed {
        logic ro_zero;
        logic ro_last;
        logic ro_lt_nr;
        logic ro_lt_np;
        logic ro_odd;
        logic cc_zero;
        logic cc_eq_nr;
        logic cc_last;
        logic cc_odd;
    } sgts_flag_t;

    function automatic sgts_pkg::sgts_ent_t ent(input logic [CW-1:0] c,
                                                input logic [2:0] w);
        ent = '{col: c, wgt: w};
    endfunction

    logic [NW-1:0] nr_c, np_c, mk_c;
    logic [NW:0] mq_c;
    sgts_flag_t fl_c;

    logic va_reg;
    sgts_pkg::sgts_ctx_t ctx_reg;
    sgts_flag_t fl_reg;
    logic [NW-1:0] cc_reg;
    logic [2*NW:0] prod_reg;

    logic vb_reg;
    sgts_pkg::sgts_row_t row_reg;
    sgts_pkg::sgts_row_t row_c;

    always_comb begin
        logic prolong;
        nr_c = in_ctx.n >> 1;
        np_c = {in_ctx.n[NW-2:0], 1'b0};
        prolong = (in_ctx.func == sgts_pkg::FN_PROLONG_U) ||
                  (in_ctx.func == sgts_pkg::FN_PROLONG_V) ||
                  (in_ctx.func == sgts_pkg::FN_PROLONG_P);
        // prolongation indexes the coarse row by ro/2
        mq_c = prolong ? in_q[NW+1:1] : in_q[NW:0];
        mk_c = ((in_ctx.func == sgts_pkg::FN_RESTRICT_U) ||
                (in_ctx.func == sgts_pkg::FN_PROLONG_U)) ? in_ctx.n + 1'b1 : in_ctx.n;
        fl_c.ro_zero = (in_q == '0);
        fl_c.ro_last = (in_q == QW'(np_c - 1'b1));
        fl_c.ro_lt_nr = (in_q < QW'(nr_c));
        fl_c.ro_lt_np = (in_q < QW'(np_c));
        fl_c.ro_odd = in_q[0];
        fl_c.cc_zero = (in_rem == '0);
        fl_c.cc_eq_nr = (in_rem == nr_c);
        fl_c.cc_last = (in_rem == NW'(np_c - 1'b1));
        fl_c.cc_odd = in_rem[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg <= in_ctx;
            fl_reg <= fl_c;
            cc_reg <= in_rem;
            prod_reg <= mq_c * mk_c;
            row_reg <= row_c;
        end
    end

    always_comb begin
        logic [CW-1:0] n21, b, b2, c0, nb, side, cv, sv;
        logic ro_edge, edgec;
        n21 = CW'(ctx_reg.n);
        b = CW'({prod_reg, 1'b0}) + CW'({cc_reg, 1'b0});
        b2 = b + n21 + 1'b1;
        c0 = CW'(prod_reg) + CW'(cc_reg >> 1);
        nb = fl_reg.ro_odd ? c0 + n21 + 1'b1 : c0 - n21 - 1'b1;
        side = fl_reg.cc_odd ? c0 + 1'b1 : c0 - 1'b1;
        cv = fl_reg.ro_odd ? c0 + n21 : c0 - n21;
        sv = fl_reg.ro_odd ? side + n21 : side - n21;
        ro_edge = fl_reg.ro_zero || fl_reg.ro_last;
        edgec = fl_reg.cc_zero || fl_reg.cc_last;
        row_c = '0;
        case (ctx_reg.func)
            sgts_pkg::FN_RESTRICT_U: begin
                row_c.divr = sgts_pkg::DIVR_UV;
                if (ctx_reg.inr && !fl_reg.cc_zero && !fl_reg.cc_eq_nr) begin
                    row_c.ent[0] = ent(b, 3'd2);
                    row_c.ent[1] = ent(b + 1'b1, 3'd1);
                    row_c.ent[2] = ent(b - 1'b1, 3'd1);
                    row_c.ent[3] = ent(b2, 3'd2);
                    row_c.ent[4] = ent(b2 + 1'b1, 3'd1);
                    row_c.ent[5] = ent(b2 - 1'b1, 3'd1);
                    row_c.cnt = 3'd6;
                end
            end
            sgts_pkg::FN_RESTRICT_V: begin
                row_c.divr = sgts_pkg::DIVR_UV;
                if (ctx_reg.inr && ctx_reg.n > NW'(1) && !fl_reg.ro_zero &&
                    fl_reg.ro_lt_nr) begin
                    row_c.ent[0] = ent(b, 3'd2);
                    row_c.ent[1] = ent(b + 1'b1, 3'd2);
                    row_c.ent[2] = ent(b - n21, 3'd1);
                    row_c.ent[3] = ent(b + 1'b1 - n21, 3'd1);
                    row_c.ent[4] = ent(b + n21, 3'd1);
                    row_c.ent[5] = ent(b + 1'b1 + n21, 3'd1);
                    row_c.cnt = 3'd6;
                end
            end
            sgts_pkg::FN_RESTRICT_P: begin
                row_c.divr = sgts_pkg::DIVR_RP;
                if (ctx_reg.inr && ctx_reg.n > NW'(1)) begin
                    row_c.ent[0] = ent(b, 3'd1);
                    row_c.ent[1] = ent(b + 1'b1, 3'd1);
                    row_c.ent[2] = ent(b + n21, 3'd1);
                    row_c.ent[3] = ent(b + 1'b1 + n21, 3'd1);
                    row_c.cnt = 3'd4;
                end
            end
            sgts_pkg::FN_PROLONG_U: begin
                row_c.divr = sgts_pkg::DIVR_UV;
                if (ctx_reg.inr) begin
                    if (!fl_reg.cc_odd) begin
                        row_c.ent[0] = ent(c0, 3'd6);
                        row_c.ent[1] = ent(nb, 3'd2);
                        row_c.cnt = ro_edge ? 3'd1 : 3'd2;
                    end else begin
                        row_c.ent[0] = ent(c0, 3'd3);
                        row_c.ent[1] = ent(c0 + 1'b1, 3'd3);
                        row_c.ent[2] = ent(nb, 3'd1);
                        row_c.ent[3] = ent(nb + 1'b1, 3'd1);
                        row_c.cnt = ro_edge ? 3'd2 : 3'd4;
                    end
                end
            end
            sgts_pkg::FN_PROLONG_V: begin
                row_c.divr = sgts_pkg::DIVR_UV;
                if (ctx_reg.inr && !fl_reg.ro_zero && fl_reg.ro_lt_np) begin
                    if (!fl_reg.ro_odd) begin
                        row_c.ent[0] = ent(c0, 3'd6);
                        row_c.ent[1] = ent(side, 3'd2);
                        row_c.cnt = edgec ? 3'd1 : 3'd2;
                    end else begin
                        row_c.ent[0] = ent(c0, 3'd3);
                        row_c.ent[1] = ent(c0 + n21, 3'd3);
                        row_c.ent[2] = ent(side, 3'd1);
                        row_c.ent[3] = ent(side + n21, 3'd1);
                        row_c.cnt = edgec ? 3'd2 : 3'd4;
                    end
                end
            end
            sgts_pkg::FN_PROLONG_P: begin
                row_c.divr = sgts_pkg::DIVR_PP;
                if (ctx_reg.inr) begin
                    row_c.ent[0] = ent(c0, 3'd3);
                    if (ro_edge) begin
                        row_c.ent[1] = ent(side, 3'd1);
                        row_c.cnt = edgec ? 3'd1 : 3'd2;
                    end else begin
                        row_c.ent[1] = ent(cv, 3'd1);
                        row_c.ent[2] = ent(side, 3'd1);
                        row_c.ent[3] = ent(sv, 3'd1);
                        row_c.cnt = edgec ? 3'd2 : 3'd4;
                    end
                end
            end
            default: begin
                row_c.cnt = '0;
            end
        endcase
    end

    assign out_valid = vb_reg;
    assign out_row = row_reg;
endmodule
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [sgts_pkg::COL_W-1:0] col;
        logic [sgts_pkg::WGT_W-1:0] wgt;
        logic [sgts_pkg::DIVR_W-1:0] divr;
        logic last;
    } entry_t;

    class stencil_scoreboard;
        entry_t expected_entries[$];
        logic [sgts_pkg::GRID_W-1:0] grid_size;
        logic [63:0] row_cols[$];
        int row_wgts[$];

        function new();
            grid_size = sgts_pkg::GRID_RESET;
        endfunction

        function void add(logic [63:0] col, int w);
            row_cols.push_back(col);
            row_wgts.push_back(w);
        endfunction

        // Expands one row of the transfer matrix into its nonzero entries.
        function void note_row(logic [sgts_pkg::FUNC_W-1:0] func,
                               logic [sgts_pkg::ROW_W-1:0] row_idx);
            logic [63:0] n, r, nr, np, ro, cc, b, b2, c0, nb, side, vo;
            logic [sgts_pkg::DIVR_W-1:0] divr;
            bit edge_row, edge_col;
            entry_t e;
            row_cols.delete();
            row_wgts.delete();
            r = row_idx;
            n = (grid_size > sgts_pkg::DEF_MAX_GRID) ? sgts_pkg::DEF_MAX_GRID : grid_size;
            nr = n / 2;
            np = 2 * n;
            divr = sgts_pkg::DIVR_UV;
            case (func)
                sgts_pkg::FN_RESTRICT_U: begin
                    if (r < nr * (nr + 1)) begin
                        ro = r / (nr + 1);
                        cc = r % (nr + 1);
                        if (cc != 0 && cc != nr) begin
                            b = ro * 2 * (n + 1) + cc * 2;
                            b2 = b + n + 1;
                            add(b, 2); add(b + 1, 1); add(b - 1, 1);
                            add(b2, 2); add(b2 + 1, 1); add(b2 - 1, 1);
                        end
                    end
                end
                sgts_pkg::FN_RESTRICT_V: begin
                    if (nr != 0 && r < nr * (nr + 1) && r >= nr && r < nr * nr) begin
                        b = (r / nr) * 2 * n + (r % nr) * 2;
                        add(b, 2); add(b + 1, 2);
                        add(b - n, 1); add(b + 1 - n, 1);
                        add(b + n, 1); add(b + 1 + n, 1);
                    end
                end
                sgts_pkg::FN_RESTRICT_P: begin
                    divr = sgts_pkg::DIVR_RP;
                    if (nr != 0 && r < nr * nr) begin
                        b = (r / nr) * 2 * n + (r % nr) * 2;
                        add(b, 1); add(b + 1, 1); add(b + n, 1); add(b + 1 + n, 1);
                    end
                end
                sgts_pkg::FN_PROLONG_U: begin
                    if (r < np * (np + 1)) begin
                        ro = r / (np + 1);
                        cc = r % (np + 1);
                        c0 = (ro / 2) * (n + 1) + cc / 2;
                        edge_row = (ro == 0 || ro == np - 1);
                        nb = (ro % 2 == 0) ? c0 - (n + 1) : c0 + (n + 1);
                        if (cc % 2 == 0) begin
                            add(c0, 6);
                            if (!edge_row) add(nb, 2);
                        end else begin
                            add(c0, 3); add(c0 + 1, 3);
                            if (!edge_row) begin
                                add(nb, 1); add(nb + 1, 1);
                            end
                        end
                    end
                end
                sgts_pkg::FN_PROLONG_V: begin
                    if (r < np * (np + 1)) begin
                        ro = r / np;
                        cc = r % np;
                        if (ro != 0 && ro < np) begin
                            c0 = (ro / 2) * n + cc / 2;
                            edge_col = (cc == 0 || cc == np - 1);
                            side = (cc % 2 == 0) ? c0 - 1 : c0 + 1;
                            if (ro % 2 == 0) begin
                                add(c0, 6);
                                if (!edge_col) add(side, 2);
                            end else begin
                                add(c0, 3); add(c0 + n, 3);
                                if (!edge_col) begin
                                    add(side, 1); add(side + n, 1);
                                end
                            end
                        end
                    end
                end
                sgts_pkg::FN_PROLONG_P: begin
                    divr = sgts_pkg::DIVR_PP;
                    if (r < np * np) begin
                        ro = r / np;
                        cc = r % np;
                        c0 = (ro / 2) * n + cc / 2;
                        edge_col = (cc == 0 || cc == np - 1);
                        side = (cc % 2 == 0) ? c0 - 1 : c0 + 1;
                        add(c0, 3);
                        if (ro == 0 || ro == np - 1) begin
                            if (!edge_col) add(side, 1);
                        end else begin
                            vo = (ro % 2 != 0) ? n : 64'd0 - n;
                            add(c0 + vo, 1);
                            if (!edge_col) begin
                                add(side, 1); add(side + vo, 1);
                            end
                        end
                    end
                end
                default: ;
            endcase
            foreach (row_cols[i]) begin
                e.col = row_cols[i][sgts_pkg::COL_W-1:0];
                e.wgt = row_wgts[i][sgts_pkg::WGT_W-1:0];
                e.divr = divr;
                e.last = (i == row_cols.size() - 1);
                expected_entries.push_back(e);
            end
        endfunction

        // Returns an empty string on a match, else a description.
        function string check_entry(logic [31:0] data, logic last);
            entry_t e;
            if (expected_entries.size() == 0)
                return $sformatf("unexpected entry data=%h last=%b", data, last);
            e = expected_entries.pop_front();
            if (data[20:0] !== e.col || data[23:21] !== e.wgt || data[27:24] !== e.divr
                    || last !== e.last)
                return $sformatf("entry mismatch: got col=%0d w=%0d d=%0d l=%b, want col=%0d w=%0d d=%0d l=%b",
                    data[20:0], data[23:21], data[27:24], last, e.col, e.wgt, e.divr, e.last);
            return "";
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [10:0] cfg_wr_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;
    logic m_tlast;

    stencil_scoreboard sb = new();
    int errors = 0;
    int rows_sent = 0;
    int stall_cycles = 0;
    int idle_mode = 0;  // 0: sender 30%/receiver 87%, 1: swapped, 2: none

    always #2 aclk = ~aclk;

    staggered_grid_transfer_stencil dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    task automatic report(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        string msg;
        if (aresetn) begin
            if (cfg_wr_en) sb.grid_size = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                sb.note_row(s_tuser, s_tdata[22:0]);
                rows_sent++;
            end
            if (m_tvalid && m_tready) begin
                msg = sb.check_entry(m_tdata, m_tlast);
                if (msg != "") report(msg);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver backpressure.
    always @(negedge aclk) begin
        case (idle_mode)
            0: m_tready <= ($urandom_range(99) >= 87);
            1: m_tready <= ($urandom_range(99) >= 30);
            default: m_tready <= 1'b1;
        endcase
    end

    task automatic send_row(logic [sgts_pkg::FUNC_W-1:0] func,
                            logic [sgts_pkg::ROW_W-1:0] row_idx);
        int start_cnt;
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 30 : (idle_mode == 1) ? 87 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        start_cnt = rows_sent;
        s_tvalid = 1'b1;
        s_tuser = func;
        s_tdata = {1'b0, row_idx};
        do @(negedge aclk); while (rows_sent == start_cnt);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.expected_entries.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_grid(logic [10:0] value);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic random_rows(int count);
        logic [63:0] n, lim;
        logic [sgts_pkg::FUNC_W-1:0] f;
        logic [sgts_pkg::ROW_W-1:0] r;
        n = (sb.grid_size > sgts_pkg::DEF_MAX_GRID) ? sgts_pkg::DEF_MAX_GRID : sb.grid_size;
        lim = 4 * n * n + 2 * n + 4;
        repeat (count) begin
            f = ($urandom_range(19) == 0) ? $urandom_range(7, 6) : $urandom_range(5);
            if ($urandom_range(9) == 0) r = $urandom;
            else r = $urandom_range(lim);
            send_row(f, r);
        end
    endtask

    logic [10:0] grids[9] = '{11'd16, 11'd2, 11'd3, 11'd1, 11'd0, 11'd1024, 11'd2047,
                              11'd5, 11'd8};

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed rows at the reset grid size (16).
        idle_mode = 2;
        for (int f = 0; f < 8; f++) begin
            send_row(f, 23'd0);
            send_row(f, 23'd9);
        end
        send_row(sgts_pkg::FN_RESTRICT_U, 23'd8);         // right edge
        send_row(sgts_pkg::FN_RESTRICT_V, 23'd64);        // top edge
        send_row(sgts_pkg::FN_RESTRICT_P, 23'd63);        // last row
        send_row(sgts_pkg::FN_RESTRICT_P, 23'd64);        // out of range
        send_row(sgts_pkg::FN_PROLONG_U, 23'd32 * 33);    // just past the last fine row
        send_row(sgts_pkg::FN_PROLONG_V, 23'd32 * 32);    // top row
        send_row(sgts_pkg::FN_PROLONG_P, 23'd1023);       // corner
        send_row(sgts_pkg::FN_PROLONG_U, 23'h7FFFFF);
        send_row(sgts_pkg::FN_PROLONG_P, 23'd4198399);
        drain();

        for (int p = 0; p < 9; p++) begin
            idle_mode = p % 3;
            if (p != 0) write_grid(grids[p]);
            if (grids[p] == 11'd1024) begin
                send_row(sgts_pkg::FN_PROLONG_U, 23'd4196351);
                send_row(sgts_pkg::FN_PROLONG_V, 23'd4196351);
                send_row(sgts_pkg::FN_PROLONG_P, 23'd4194303);
            end
            random_rows(14);
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/sgts_pkg.sv
src/sgts_prep.sv
src/sgts_div.sv
src/sgts_gen.sv
src/staggered_grid_transfer_stencil.sv
test/tb_top.sv
